// ----- design/ptem_pkg.sv -----
// shared types, constants and helpers of the phase tracking error monitor
package ptem_pkg;

  localparam int unsigned ERR_W     = 21;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned PHASE_W   = 4;
  localparam int unsigned NUM_SLOTS = 5;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIV_STEPS = ERR_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  localparam logic [ERR_W-1:0] ERR_SUM_MAX   = ERR_W'(1066666);
  localparam logic [VAL_W-1:0] THRESHOLD_RST = '1;

  // test phases that accumulate error
  localparam logic [PHASE_W-1:0] PHASE_1  = 4'd1;
  localparam logic [PHASE_W-1:0] PHASE_3  = 4'd3;
  localparam logic [PHASE_W-1:0] PHASE_5  = 4'd5;
  localparam logic [PHASE_W-1:0] PHASE_6  = 4'd6;
  localparam logic [PHASE_W-1:0] PHASE_8  = 4'd8;
  localparam logic [PHASE_W-1:0] PHASE_10 = 4'd10;

  // slot of stored means
  localparam logic [SLOT_W-1:0] SLOT_P1  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_P3  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_P5  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_P8  = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_P10 = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE1_TIME  = 3'd0,
    CFG_PHASE3_TIME  = 3'd1,
    CFG_PHASE5_TIME  = 3'd2,
    CFG_PHASE6_TIME  = 3'd3,
    CFG_PHASE8_TIME  = 3'd4,
    CFG_PHASE10_TIME = 3'd5,
    CFG_THRESHOLD    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [PHASE_W-1:0] test_phase;
    logic [VAL_W-1:0]   setpoint_angle;
    logic [VAL_W-1:0]   position_estimate;
    logic [VAL_W-1:0]   elapsed_time;
    logic               test_enable;
  } in_t;

  typedef struct packed {
    logic             flag_phase1;
    logic             flag_phase3;
    logic             flag_phase5;
    logic             flag_phase8;
    logic             flag_phase10;
    logic [ERR_W-1:0] current_mean;
    logic [ERR_W-1:0] error_sum;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] idx;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic store;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_zero_nxt;
    logic div_zero;
    logic div_last;
  } sts_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PREP  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_STORE = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  function automatic slot_t phase_slot(input logic [PHASE_W-1:0] phase);
    slot_t s;
    s.valid = 1'b1;
    s.idx   = SLOT_P1;
    unique case (phase)
      PHASE_1:          s.idx = SLOT_P1;
      PHASE_3:          s.idx = SLOT_P3;
      PHASE_5, PHASE_6: s.idx = SLOT_P5;
      PHASE_8:          s.idx = SLOT_P8;
      PHASE_10:         s.idx = SLOT_P10;
      default:          s.valid = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// ----- design/ptem_ctrl.sv -----
// controller state machine of the phase tracking error monitor
module ptem_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ptem_pkg::sts_t sts,
  output ptem_pkg::cmd_t cmd
);

  ptem_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic accept;

  assign in_ready  = (state_r == ptem_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ptem_pkg::ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = ptem_pkg::ST_PREP;
        end
      end
      ptem_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.div_zero_nxt ? ptem_pkg::ST_STORE : ptem_pkg::ST_DIV;
      end
      ptem_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ptem_pkg::ST_STORE;
        end
      end
      ptem_pkg::ST_STORE: begin
        cmd.store = 1'b1;
        state_nxt = ptem_pkg::ST_OUT;
      end
      ptem_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ptem_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptem_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptem_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ptem_pkg::ST_PREP)
    else $error("accepted transaction did not start preparation");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ptem_pkg::ST_DIV |-> !sts.div_zero)
    else $error("division running with zero divisor");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptem_pkg::ST_OUT && out_free) |=> out_valid_r)
    else $error("result not presented after load");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ptem_pkg::ST_OUT))
    else $error("result presented outside output state");

endmodule

// ----- design/ptem_dp.sv -----
// datapath of the phase tracking error monitor: registers, accumulator, divider, slots
module ptem_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ptem_pkg::in_t                     in_data,
  output ptem_pkg::out_t                    out_data,
  input  logic                              cfg_wr_en,
  input  logic [ptem_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptem_pkg::VAL_W-1:0]        cfg_data,
  input  ptem_pkg::cmd_t                    cmd,
  output ptem_pkg::sts_t                    sts
);

  localparam int unsigned EW = ptem_pkg::ERR_W;
  localparam int unsigned VW = ptem_pkg::VAL_W;

  logic [VW-1:0] p1_time_r, p3_time_r, p5_time_r, p6_time_r, p8_time_r, p10_time_r;
  logic [VW-1:0] thr_r;

  ptem_pkg::in_t item_r;
  logic          prev_en_r;
  logic [EW-1:0] acc_r, acc_nxt;
  logic [EW-1:0] means_r [ptem_pkg::NUM_SLOTS];
  logic [VW-1:0] div_r, div_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [EW-1:0] quo_r, quo_nxt;
  logic [ptem_pkg::CNT_W-1:0] cnt_r;
  ptem_pkg::out_t out_r;

  ptem_pkg::slot_t slot;
  logic [VW-1:0]   diff;
  logic [EW:0]     sum_w;
  logic [VW:0]     ref_w;
  logic [VW:0]     trial;
  logic            ge;
  logic [EW-1:0]   mean_w;
  logic            rise;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_time_r  <= '0;
      p3_time_r  <= '0;
      p5_time_r  <= '0;
      p6_time_r  <= '0;
      p8_time_r  <= '0;
      p10_time_r <= '0;
      thr_r      <= ptem_pkg::THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ptem_pkg::CFG_PHASE1_TIME:  p1_time_r  <= cfg_data;
        ptem_pkg::CFG_PHASE3_TIME:  p3_time_r  <= cfg_data;
        ptem_pkg::CFG_PHASE5_TIME:  p5_time_r  <= cfg_data;
        ptem_pkg::CFG_PHASE6_TIME:  p6_time_r  <= cfg_data;
        ptem_pkg::CFG_PHASE8_TIME:  p8_time_r  <= cfg_data;
        ptem_pkg::CFG_PHASE10_TIME: p10_time_r <= cfg_data;
        ptem_pkg::CFG_THRESHOLD:    thr_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign slot = ptem_pkg::phase_slot(item_r.test_phase);
  assign diff = (item_r.setpoint_angle >= item_r.position_estimate) ?
                (item_r.setpoint_angle - item_r.position_estimate) :
                (item_r.position_estimate - item_r.setpoint_angle);
  assign sum_w = {1'b0, acc_r} + (EW+1)'(diff);

  // phase reference, 17 bits for the five/six sum
  always_comb begin
    unique case (item_r.test_phase)
      ptem_pkg::PHASE_1:  ref_w = {1'b0, p1_time_r};
      ptem_pkg::PHASE_3:  ref_w = {1'b0, p3_time_r};
      ptem_pkg::PHASE_5,
      ptem_pkg::PHASE_6:  ref_w = {1'b0, p5_time_r} + {1'b0, p6_time_r};
      ptem_pkg::PHASE_8:  ref_w = {1'b0, p8_time_r};
      ptem_pkg::PHASE_10: ref_w = {1'b0, p10_time_r};
      default:            ref_w = '0;
    endcase
  end

  // restoring division step
  assign trial = {rem_r, quo_r[EW-1]};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    acc_nxt = acc_r;
    div_nxt = div_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.prep) begin
      if (!slot.valid) begin
        acc_nxt = '0;
      end else if (sum_w > {1'b0, ptem_pkg::ERR_SUM_MAX}) begin
        acc_nxt = ptem_pkg::ERR_SUM_MAX;
      end else begin
        acc_nxt = sum_w[EW-1:0];
      end
      div_nxt = (ref_w > {1'b0, item_r.elapsed_time}) ?
                VW'(ref_w - {1'b0, item_r.elapsed_time}) : '0;
      rem_nxt = '0;
      quo_nxt = acc_nxt;
    end else if (cmd.div_step) begin
      rem_nxt = ge ? VW'(trial - {1'b0, div_r}) : trial[VW-1:0];
      quo_nxt = {quo_r[EW-2:0], ge};
    end
  end

  assign mean_w = (div_r == '0) ? '0 : quo_r;
  assign rise   = item_r.test_enable && !prev_en_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.out_load) begin
      out_r.flag_phase1  <= (means_r[ptem_pkg::SLOT_P1]  >= EW'(thr_r));
      out_r.flag_phase3  <= (means_r[ptem_pkg::SLOT_P3]  >= EW'(thr_r));
      out_r.flag_phase5  <= (means_r[ptem_pkg::SLOT_P5]  >= EW'(thr_r));
      out_r.flag_phase8  <= (means_r[ptem_pkg::SLOT_P8]  >= EW'(thr_r));
      out_r.flag_phase10 <= (means_r[ptem_pkg::SLOT_P10] >= EW'(thr_r));
      out_r.current_mean <= mean_w;
      out_r.error_sum    <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      prev_en_r <= 1'b0;
      cnt_r     <= '0;
      div_r     <= '0;
      rem_r     <= '0;
      quo_r     <= '0;
      for (int i = 0; i < ptem_pkg::NUM_SLOTS; i++) begin
        means_r[i] <= '0;
      end
    end else begin
      acc_r <= acc_nxt;
      div_r <= div_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      if (cmd.prep) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.store) begin
        prev_en_r <= item_r.test_enable;
        if (rise) begin
          for (int i = 0; i < ptem_pkg::NUM_SLOTS; i++) begin
            means_r[i] <= '0;
          end
        end else if (slot.valid) begin
          means_r[slot.idx] <= mean_w;
        end
      end
    end
  end

  assign sts.div_zero_nxt = (div_nxt == '0);
  assign sts.div_zero     = (div_r == '0);
  assign sts.div_last     = (cnt_r == ptem_pkg::CNT_W'(ptem_pkg::DIV_STEPS - 1));

  assign out_data = out_r;

  a_acc_sat: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= ptem_pkg::ERR_SUM_MAX)
    else $error("accumulator above saturation limit");

  a_prev_en: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |=> prev_en_r == $past(item_r.test_enable))
    else $error("previous enable not taken at store");

  a_quo_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.prep && !cmd.div_step) |=> $stable(quo_r))
    else $error("quotient changed outside division");

endmodule

// ----- design/phase_tracking_error_monitor_unit.sv -----
// top level of the phase tracking error monitor
// an input transaction goes through the prepare, divide, store and output states to result valid;
//   divide is skipped when the divisor is zero; a new transaction is accepted once the result is
//   loaded; the 21-step serial divider produces one quotient bit per cycle
// the result register frees the input side while a result waits to be taken
// reset: synchronous active-low rst_n clears accumulator, slots, enable history and
//   timing registers; threshold resets to all ones
module phase_tracking_error_monitor_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ptem_pkg::in_t                   in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output ptem_pkg::out_t                  out_data,
  // configuration write port
  input  logic                            cfg_wr_en,
  input  logic [ptem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptem_pkg::VAL_W-1:0]      cfg_data
);

  // command and status between controller and datapath
  ptem_pkg::cmd_t cmd;
  ptem_pkg::sts_t sts;

  // controller: sequences load, accumulate, divide, store and result transaction
  ptem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: timing registers, saturating accumulator, serial divider, mean slots
  ptem_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
